@@ design/lld_pkg.sv @@
// shared types, codes and constants for the least loaded core dispatcher
`timescale 1ns / 1ps

package lld_pkg;

  localparam int CORES_DEFAULT = 32;
  localparam int CORES_MAX     = 32;

  localparam int FUNC_W  = 3;
  localparam int CORE_W  = 5;
  localparam int MASK_W  = 32;
  localparam int TASK_W  = 32;
  localparam int TYPE_W  = 5;
  localparam int LOAD_W  = 16;
  localparam int PEND_W  = 31;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0]  ONLINE_RESET = 6'd32;
  localparam logic [LOAD_W-1:0] LOAD_MAX     = 16'hFFFF;
  localparam logic [TYPE_W-1:0] IPI_NONE     = 5'd0;

  // operation codes; the two remaining codes are rejected
  typedef enum logic [FUNC_W-1:0] {
    FN_PICK     = 3'd0,
    FN_DISPATCH = 3'd1,
    FN_TICK     = 3'd2,
    FN_SEND     = 3'd3,
    FN_HANDLE   = 3'd4,
    FN_QUERY    = 3'd5
  } lld_func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CORE_W-1:0] core;
    logic [MASK_W-1:0] allow_mask;
    logic [TASK_W-1:0] task_id;
    logic [TYPE_W-1:0] ipi_type;
  } lld_req_t;

  typedef struct packed {
    logic              status;
    logic [CORE_W-1:0] picked_core;
    logic [PEND_W-1:0] pending_ipis;
    logic [TASK_W-1:0] core_task;
    logic [LOAD_W-1:0] core_load;
    logic [CNT_W-1:0]  core_switches;
    logic [CNT_W-1:0]  dispatch_count;
    logic [CNT_W-1:0]  migration_count;
    logic [CNT_W-1:0]  ipi_sent_count;
    logic [CNT_W-1:0]  ipi_handled_count;
    logic [MASK_W-1:0] online_mask;
  } lld_rsp_t;

  // one row of per-core state
  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [TASK_W-1:0] task_id;
    logic [PEND_W-1:0] pending;
    logic [CNT_W-1:0]  switches;
  } lld_row_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic core_rd;
    logic update;
    logic present;
  } lld_cmd_t;

  typedef struct packed {
    logic req_pick;
    logic scan_last;
  } lld_stat_t;

endpackage

@@ design/lld_chan_if.sv @@
// valid/ready channel carrying one payload item per transfer
`timescale 1ns / 1ps

interface lld_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/lld_ctrl.sv @@
// sequencing controller: accept, scan, read, update, present
`timescale 1ns / 1ps

module lld_ctrl
  import lld_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  lld_stat_t stat,
  output lld_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPDATE,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.req_pick ? S_SCAN : S_READ;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.core_rd = 1'b1;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.present = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.present) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/lld_datapath.sv @@
// per-core row memory, load scan comparator, counters and result registers
`timescale 1ns / 1ps

module lld_datapath
  import lld_pkg::*;
#(
  parameter int CORES = CORES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  lld_cmd_t         cmd,
  output lld_stat_t        stat,
  input  lld_req_t         req_pl,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output lld_rsp_t         rsp_pl
);

  localparam int CIW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam logic [CFG_W-1:0] CORES_C = CFG_W'(CORES);
  localparam logic [CIW-1:0]   LAST_IDX = CIW'(CORES - 1);

  // captured request
  logic [FUNC_W-1:0] func_q;
  logic [CORE_W-1:0] core_q;
  logic [MASK_W-1:0] aff_q;
  logic [TASK_W-1:0] tid_q;
  logic [TYPE_W-1:0] typ_q;

  logic [CFG_W-1:0] online_limit;
  logic [CFG_W-1:0] live_n;
  logic [MASK_W-1:0] live_mask;
  logic [MASK_W-1:0] allow;
  logic [CORES-1:0]  allow_c;
  logic              on;

  // row memory with per-row valid bits
  lld_row_t          mem [CORES];
  logic [CORES-1:0]  row_vld;
  logic [CIW-1:0]    rd_addr;
  lld_row_t          rd_row;
  logic              rd_hit;
  lld_row_t          cur_row;
  lld_row_t          new_row;
  logic              row_we;
  logic [CIW-1:0]    core_idx;

  // scan
  logic [CIW-1:0]    scan_cnt;
  logic              cmp_en;
  logic [CIW-1:0]    cmp_idx;
  logic              found;
  logic [LOAD_W-1:0] best;
  logic [CIW-1:0]    pick_idx;

  logic [CNT_W-1:0]  dispatch_total;
  logic [CNT_W-1:0]  migration_total;
  logic [CNT_W-1:0]  sent_total;
  logic [CNT_W-1:0]  handled_total;
  logic [CNT_W-1:0]  dispatch_next;
  logic [CNT_W-1:0]  migration_next;
  logic [CNT_W-1:0]  sent_next;
  logic [CNT_W-1:0]  handled_next;

  lld_rsp_t          res;
  lld_rsp_t          res_next;
  logic              status_v;

  assign core_idx = core_q[CIW-1:0];

  // online count clamped to 1..CORES
  always_comb begin
    if (online_limit == '0) begin
      live_n = CFG_W'(1);
    end else if (online_limit > CORES_C) begin
      live_n = CORES_C;
    end else begin
      live_n = online_limit;
    end
    for (int i = 0; i < MASK_W; i++) begin
      live_mask[i] = (CFG_W'(i) < live_n);
    end
  end

  assign allow   = aff_q & live_mask;
  assign allow_c = allow[CORES-1:0];
  assign on      = ({1'b0, core_q} < live_n);

  assign stat.req_pick  = (req_pl.func == FN_PICK);
  assign stat.scan_last = (scan_cnt == LAST_IDX);

  assign rd_addr = cmd.scan_rd ? scan_cnt : core_idx;
  assign cur_row = rd_hit ? rd_row : '0;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      online_limit <= cfg_data;
    end
    if (rst) begin
      online_limit <= ONLINE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req_pl.func;
      core_q <= req_pl.core;
      aff_q  <= req_pl.allow_mask;
      tid_q  <= req_pl.task_id;
      typ_q  <= req_pl.ipi_type;
    end
  end

  // memory read and write ports
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.core_rd) begin
      rd_row <= mem[rd_addr];
      rd_hit <= row_vld[rd_addr];
    end
    if (row_we) begin
      mem[core_idx] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (row_we) begin
      row_vld[core_idx] <= 1'b1;
    end
  end

  // scan: one row per cycle, compare lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
    end
    cmp_idx <= scan_cnt;
    if (cmd.capture) begin
      scan_cnt <= '0;
    end else if (cmd.scan_rd) begin
      scan_cnt <= scan_cnt + CIW'(1);
    end
    if (cmd.capture) begin
      found    <= 1'b0;
      best     <= '0;
      pick_idx <= '0;
    end else if (cmp_en && allow_c[cmp_idx] && (!found || cur_row.load < best)) begin
      found    <= 1'b1;
      best     <= cur_row.load;
      pick_idx <= cmp_idx;
    end
  end

  // row update and result
  always_comb begin
    new_row        = cur_row;
    row_we         = 1'b0;
    status_v       = 1'b0;
    dispatch_next  = dispatch_total;
    migration_next = migration_total;
    sent_next      = sent_total;
    handled_next   = handled_total;
    unique case (func_q)
      FN_PICK: begin
        status_v = !found;
      end
      FN_DISPATCH: begin
        if (!on) begin
          status_v = 1'b1;
        end else begin
          row_we           = 1'b1;
          new_row.task_id  = tid_q;
          new_row.switches = cur_row.switches + CNT_W'(1);
          if (cur_row.load != LOAD_MAX) begin
            new_row.load = cur_row.load + LOAD_W'(1);
          end
          if (cur_row.task_id != tid_q) begin
            migration_next = migration_total + CNT_W'(1);
          end
          dispatch_next = dispatch_total + CNT_W'(1);
        end
      end
      FN_TICK: begin
        if (!on) begin
          status_v = 1'b1;
        end else begin
          row_we = 1'b1;
          if (cur_row.load != '0) begin
            new_row.load = cur_row.load - LOAD_W'(1);
          end
        end
      end
      FN_SEND: begin
        if (!on || typ_q == IPI_NONE) begin
          status_v = 1'b1;
        end else begin
          row_we          = 1'b1;
          new_row.pending = cur_row.pending | (PEND_W'(1) << (typ_q - TYPE_W'(1)));
          sent_next       = sent_total + CNT_W'(1);
        end
      end
      FN_HANDLE: begin
        if (!on) begin
          status_v = 1'b1;
        end else begin
          row_we          = 1'b1;
          new_row.pending = '0;
          if (cur_row.pending != '0) begin
            handled_next = handled_total + CNT_W'(1);
          end
        end
      end
      FN_QUERY: begin
        status_v = !on;
      end
      default: begin
        status_v = 1'b1;
      end
    endcase
    row_we = row_we && cmd.update;

    res_next                   = '0;
    res_next.status            = status_v;
    res_next.picked_core       = (func_q == FN_PICK && found) ? CORE_W'(pick_idx) : '0;
    if (on) begin
      res_next.pending_ipis  = (func_q == FN_HANDLE) ? cur_row.pending : new_row.pending;
      res_next.core_task     = new_row.task_id;
      res_next.core_load     = new_row.load;
      res_next.core_switches = new_row.switches;
    end
    res_next.dispatch_count    = dispatch_next;
    res_next.migration_count   = migration_next;
    res_next.ipi_sent_count    = sent_next;
    res_next.ipi_handled_count = handled_next;
    res_next.online_mask       = live_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dispatch_total  <= '0;
      migration_total <= '0;
      sent_total      <= '0;
      handled_total   <= '0;
    end else if (cmd.update) begin
      dispatch_total  <= dispatch_next;
      migration_total <= migration_next;
      sent_total      <= sent_next;
      handled_total   <= handled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res <= res_next;
    end
    if (cmd.present) begin
      rsp_pl <= res;
    end
  end

endmodule

@@ design/least_loaded_core_dispatcher_unit.sv @@
// top level of the least loaded core dispatcher with interrupt mailboxes
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// req       in   valid / ready      lld_req_t: func, core, allow_mask, task_id, ipi_type
// rsp       out  valid / ready      lld_rsp_t: status, picked_core, per-core and global fields
// cfg       in   cfg_we, no wait    cfg_data: online_limit
//
// pick goes through accept, scan, read, update and hold; every other operation skips the scan:
// the load scan reads one row of the row memory per cycle
// rst clears the state machine, the row valid bits (rows then read as zero),
// the counters and sets online_limit to 32; no clearing pass is needed
// a new request is taken while the previous result waits in the output register;
// a stalled rsp only holds the block in its final step

module least_loaded_core_dispatcher_unit
  import lld_pkg::*;
#(
  parameter int CORES = CORES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  lld_chan_if.sink         req,
  lld_chan_if.source       rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  // controller to datapath command and status
  lld_cmd_t  cmd;
  lld_stat_t stat;

  lld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // row memory, scan compare, counters and result registers
  lld_datapath #(
    .CORES (CORES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_pl   (req.payload),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp_pl   (rsp.payload)
  );

  // busy after every request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a previous one is in flight");

  // presenting a result always shows it on the next cycle
  a_present_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.present |=> rsp.valid)
    else $error("result not shown after present");

  // a nonzero picked core only comes with an ok status
  a_pick_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.picked_core != '0) |-> (rsp.payload.status == 1'b0))
    else $error("picked core reported on a rejected request");

  // core zero is always online
  a_core0_online: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload.online_mask[0])
    else $error("online mask lost core zero");

endmodule

@@ tb/least_loaded_core_dispatcher_unit_tb.sv @@
// self-checking testbench: directed and random scheduler operations against a cycle-free predictor
`timescale 1ns / 1ps

module least_loaded_core_dispatcher_unit_tb;
  import lld_pkg::*;

  // codes the package leaves unnamed: both are rejected by the block
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam logic              ST_OK       = 1'b0;
  localparam logic              ST_REJECT   = 1'b1;

  localparam int RAND_PHASES    = 10;
  localparam int RAND_PHASE_OPS = 100;
  // a short run of back-to-back dispatches to one core
  localparam int SAT_OPS        = 20;
  localparam int HOLD_CYCLES    = 400;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  lld_chan_if #(.payload_t(lld_req_t)) req_ch ();
  lld_chan_if #(.payload_t(lld_rsp_t)) rsp_ch ();

  least_loaded_core_dispatcher_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // scheduler state as the testbench sees it
  logic [CFG_W-1:0]  online_cfg;
  logic [LOAD_W-1:0] load_tab   [CORES_MAX];
  logic [TASK_W-1:0] task_tab   [CORES_MAX];
  logic [PEND_W-1:0] pend_tab   [CORES_MAX];
  logic [CNT_W-1:0]  switch_tab [CORES_MAX];
  logic [CNT_W-1:0]  disp_total;
  logic [CNT_W-1:0]  mig_total;
  logic [CNT_W-1:0]  sent_total;
  logic [CNT_W-1:0]  handled_total;

  lld_req_t op_backlog [$];
  lld_rsp_t owed_rsp   [$];

  int fail_count  = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int rdy_tick    = 0;
  bit req_fired   = 1'b0;
  bit full_rate   = 1'b0;
  bit hold_go     = 1'b0;
  bit rsp_hold    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // online count after clamping into 1..CORES_MAX
  function automatic int unsigned live_cores();
    int unsigned n;
    n = online_cfg;
    if (n < 1) n = 1;
    if (n > CORES_MAX) n = CORES_MAX;
    return n;
  endfunction

  // applies one operation to the tracked state and returns the result it owes
  function automatic lld_rsp_t sched_step(lld_req_t r);
    lld_rsp_t          o;
    int unsigned       n;
    int unsigned       best;
    logic [MASK_W-1:0] live;
    logic [MASK_W-1:0] allowed;
    logic [CORE_W-1:0] c;
    logic              on;
    logic              taken;
    logic [PEND_W-1:0] grabbed;
    o = '0;
    n = live_cores();
    live = '1;
    if (n < 32) live = (32'd1 << n) - 32'd1;
    c = r.core;
    on = (c < n);
    taken = 1'b0;
    grabbed = '0;
    o.status = ST_OK;
    case (r.func)
      FN_PICK: begin
        allowed = r.allow_mask & live;
        if (allowed == '0) begin
          o.status = ST_REJECT;
        end else begin
          // strict compare keeps the lowest index on a tie
          best = 32'h1_0000;
          for (int i = 0; i < n; i++) begin
            if (allowed[i] && load_tab[i] < best) begin
              best = load_tab[i];
              o.picked_core = CORE_W'(i);
            end
          end
        end
      end
      FN_DISPATCH: begin
        if (!on) begin
          o.status = ST_REJECT;
        end else begin
          if (task_tab[c] != r.task_id) mig_total++;
          task_tab[c] = r.task_id;
          switch_tab[c]++;
          if (load_tab[c] != LOAD_MAX) load_tab[c]++;
          disp_total++;
        end
      end
      FN_TICK: begin
        if (!on) o.status = ST_REJECT;
        else if (load_tab[c] != '0) load_tab[c]--;
      end
      FN_SEND: begin
        if (!on || r.ipi_type == IPI_NONE) begin
          o.status = ST_REJECT;
        end else begin
          pend_tab[c][r.ipi_type - 1] = 1'b1;
          sent_total++;
        end
      end
      FN_HANDLE: begin
        if (!on) begin
          o.status = ST_REJECT;
        end else begin
          grabbed = pend_tab[c];
          taken = 1'b1;
          pend_tab[c] = '0;
          if (grabbed != '0) handled_total++;
        end
      end
      FN_QUERY: begin
        if (!on) o.status = ST_REJECT;
      end
      default: o.status = ST_REJECT;
    endcase
    // an offline core reports zeros in its per-core fields
    if (on) begin
      o.pending_ipis  = taken ? grabbed : pend_tab[c];
      o.core_task     = task_tab[c];
      o.core_load     = load_tab[c];
      o.core_switches = switch_tab[c];
    end
    o.dispatch_count    = disp_total;
    o.migration_count   = mig_total;
    o.ipi_sent_count    = sent_total;
    o.ipi_handled_count = handled_total;
    o.online_mask       = live;
    return o;
  endfunction

  function automatic lld_req_t rand_op(int unsigned n);
    lld_req_t    r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) r.func = FN_PICK;
    else if (sel < 45) r.func = FN_DISPATCH;
    else if (sel < 60) r.func = FN_TICK;
    else if (sel < 75) r.func = FN_SEND;
    else if (sel < 87) r.func = FN_HANDLE;
    else if (sel < 95) r.func = FN_QUERY;
    else if (sel < 97) r.func = FN_SPARE_LO;
    else r.func = FN_SPARE_HI;
    // mostly online cores, now and then any index
    if ($urandom_range(0, 4) != 0) r.core = CORE_W'($urandom_range(0, n - 1));
    else r.core = CORE_W'($urandom());
    case ($urandom_range(0, 4))
      0: r.allow_mask = $urandom();
      1: r.allow_mask = 32'd1 << $urandom_range(0, 31);
      2: r.allow_mask = $urandom() & $urandom() & $urandom();
      3: r.allow_mask = ~(32'd1 << $urandom_range(0, 31));
      default: r.allow_mask = ($urandom_range(0, 5) == 0) ? '0 : '1;
    endcase
    // a small pool of ids so that repeated dispatches often keep the task
    if ($urandom_range(0, 2) == 0) r.task_id = $urandom();
    else r.task_id = TASK_W'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) r.ipi_type = IPI_NONE;
    else r.ipi_type = TYPE_W'($urandom_range(1, 31));
    return r;
  endfunction

  task automatic push_op(input logic [FUNC_W-1:0] f, input logic [CORE_W-1:0] c,
                         input logic [MASK_W-1:0] m, input logic [TASK_W-1:0] t,
                         input logic [TYPE_W-1:0] y);
    lld_req_t r;
    r.func = f;
    r.core = c;
    r.allow_mask = m;
    r.task_id = t;
    r.ipi_type = y;
    op_backlog.push_back(r);
  endtask

  // every item owes exactly one result, so empty queues mean the block is idle
  task automatic drain();
    while (op_backlog.size() != 0 || owed_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_online(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    online_cfg = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // request transfer: predict the result and retire the offered item
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      owed_rsp.push_back(sched_step(req_ch.payload));
      void'(op_backlog.pop_front());
      req_fired = 1'b1;
    end
  end

  // request driver: bursts and gaps, item held until its transfer
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && !req_fired)) begin
      if (gap_left > 0 && !full_rate) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        req_ch.valid <= 1'b1;
        req_ch.payload <= op_backlog[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
          else burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    req_fired = 1'b0;
  end

  // result receiver: rotating stall pattern, overridden by the long hold-off
  always @(negedge clk) begin
    rdy_tick++;
    if (rsp_hold) begin
      rsp_ch.ready <= 1'b0;
    end else if (full_rate) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      case ((rdy_tick / 97) % 4)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
        default: rsp_ch.ready <= ((rdy_tick % 5) < 2);
      endcase
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold = 1'b0;
  end

  // result transfer: compare against the oldest owed result
  always @(posedge clk) begin
    lld_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_rsp.size() == 0) begin
        $error("result transfer with no result owed");
        fail_count++;
      end else begin
        want = owed_rsp.pop_front();
        check_field("status", want.status, rsp_ch.payload.status);
        check_field("picked_core", want.picked_core, rsp_ch.payload.picked_core);
        check_field("pending_ipis", want.pending_ipis, rsp_ch.payload.pending_ipis);
        check_field("core_task", want.core_task, rsp_ch.payload.core_task);
        check_field("core_load", want.core_load, rsp_ch.payload.core_load);
        check_field("core_switches", want.core_switches, rsp_ch.payload.core_switches);
        check_field("dispatch_count", want.dispatch_count, rsp_ch.payload.dispatch_count);
        check_field("migration_count", want.migration_count,
                    rsp_ch.payload.migration_count);
        check_field("ipi_sent_count", want.ipi_sent_count, rsp_ch.payload.ipi_sent_count);
        check_field("ipi_handled_count", want.ipi_handled_count,
                    rsp_ch.payload.ipi_handled_count);
        check_field("online_mask", want.online_mask, rsp_ch.payload.online_mask);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg [RAND_PHASES];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = ONLINE_RESET;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    online_cfg = ONLINE_RESET;
    for (int i = 0; i < CORES_MAX; i++) begin
      load_tab[i] = '0;
      task_tab[i] = '0;
      pend_tab[i] = '0;
      switch_tab[i] = '0;
    end
    disp_total = '0;
    mig_total = '0;
    sent_total = '0;
    handled_total = '0;
    phase_cfg = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd31, 6'd2, 6'd33, 6'd16, 6'd0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: all cores online from reset
    push_op(FN_QUERY, 5'd0, '0, '0, IPI_NONE);
    push_op(FN_PICK, 5'd9, '1, '0, IPI_NONE);              // all tied, lowest index
    push_op(FN_PICK, 5'd0, '0, '0, IPI_NONE);              // empty mask
    push_op(FN_DISPATCH, 5'd0, '0, '0, IPI_NONE);          // same id, no migration
    push_op(FN_DISPATCH, 5'd0, '0, '1, IPI_NONE);
    push_op(FN_DISPATCH, 5'd31, '0, 32'hA5A5_5A5A, IPI_NONE);
    push_op(FN_PICK, 5'd0, '1, '0, IPI_NONE);
    push_op(FN_PICK, 5'd31, 32'h8000_0001, '0, IPI_NONE);
    push_op(FN_PICK, 5'd4, 32'h8000_0000, '0, IPI_NONE);
    push_op(FN_TICK, 5'd0, '0, '0, IPI_NONE);
    push_op(FN_TICK, 5'd5, '0, '0, IPI_NONE);              // tick at zero load
    push_op(FN_SEND, 5'd3, '0, '0, IPI_NONE);              // type zero rejected
    push_op(FN_SEND, 5'd3, '0, '0, 5'd1);
    push_op(FN_SEND, 5'd3, '0, '0, 5'd31);
    push_op(FN_SEND, 5'd3, '0, '0, 5'd31);
    push_op(FN_QUERY, 5'd3, '0, '0, IPI_NONE);
    push_op(FN_HANDLE, 5'd3, '0, '0, IPI_NONE);
    push_op(FN_HANDLE, 5'd3, '0, '0, IPI_NONE);            // nothing pending
    push_op(FN_SPARE_LO, 5'd1, '1, '1, 5'd1);
    push_op(FN_SPARE_HI, '1, '1, '1, '1);
    push_op(FN_DISPATCH, 5'd31, '0, '1, IPI_NONE);
    drain();

    // one core online: the rest are rejected but keep their entries
    set_online(6'd1);
    push_op(FN_QUERY, 5'd31, '0, '0, IPI_NONE);
    push_op(FN_DISPATCH, 5'd1, '0, 32'h1234_5678, IPI_NONE);
    push_op(FN_TICK, 5'd31, '0, '0, IPI_NONE);
    push_op(FN_SEND, 5'd31, '0, '0, 5'd7);
    push_op(FN_HANDLE, 5'd31, '0, '0, IPI_NONE);
    push_op(FN_PICK, 5'd0, '1, '0, IPI_NONE);
    push_op(FN_PICK, 5'd0, 32'hFFFF_FFFE, '0, IPI_NONE);   // only offline cores allowed
    drain();
    set_online(6'd32);
    push_op(FN_QUERY, 5'd31, '0, '0, IPI_NONE);
    drain();

    // back-to-back dispatches to one core, then a tick, a dispatch and a pick
    @(posedge clk);
    full_rate = 1'b1;
    for (int k = 0; k < SAT_OPS; k++) begin
      push_op(FN_DISPATCH, 5'd2, '0, TASK_W'($urandom_range(0, 1)), IPI_NONE);
    end
    push_op(FN_TICK, 5'd2, '0, '0, IPI_NONE);
    push_op(FN_DISPATCH, 5'd2, '0, '0, IPI_NONE);
    push_op(FN_PICK, 5'd2, 32'h0000_0006, '0, IPI_NONE);
    drain();
    @(posedge clk);
    full_rate = 1'b0;

    // random phases over a range of online counts, clamped values among them
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      if (p == RAND_PHASES - 1) phase_cfg[p] = CFG_W'($urandom_range(0, 63));
      set_online(phase_cfg[p]);
      for (int k = 0; k < RAND_PHASE_OPS; k++) op_backlog.push_back(rand_op(live_cores()));
      if (p == 2) hold_go = 1'b1;
    end
    drain();
    repeat (2 * CORES_MAX + 16) @(posedge clk);

    if (fail_count == 0 && owed_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
